// File: design/mdns_message_stream_parser_assert.svh
// Assertion macros shared by the mDNS message stream parser RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef MDNS_MESSAGE_STREAM_PARSER_ASSERT_SVH
`define MDNS_MESSAGE_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MDNS_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MDNS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mdns_pkg.sv
// Package for the mDNS message stream parser: field widths, role and status
// codes, record type constants and the structs passed between modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mdns_pkg;

    localparam int BYTE_W  = 8;
    localparam int ROLE_W  = 4;
    localparam int SEC_W   = 2;
    localparam int IDX_W   = 16;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;
    localparam int NUM_SEC = 4;

    // Byte role codes.
    localparam logic [ROLE_W-1:0] ROLE_ID        = 4'd0;
    localparam logic [ROLE_W-1:0] ROLE_FLAGS     = 4'd1;
    localparam logic [ROLE_W-1:0] ROLE_COUNT     = 4'd2;
    localparam logic [ROLE_W-1:0] ROLE_LABEL_LEN = 4'd3;
    localparam logic [ROLE_W-1:0] ROLE_LABEL_CHR = 4'd4;
    localparam logic [ROLE_W-1:0] ROLE_NAME_END  = 4'd5;
    localparam logic [ROLE_W-1:0] ROLE_TYPE      = 4'd6;
    localparam logic [ROLE_W-1:0] ROLE_CLASS     = 4'd7;
    localparam logic [ROLE_W-1:0] ROLE_TTL       = 4'd8;
    localparam logic [ROLE_W-1:0] ROLE_RDLEN     = 4'd9;
    localparam logic [ROLE_W-1:0] ROLE_RDATA     = 4'd10;
    localparam logic [ROLE_W-1:0] ROLE_TRAILING  = 4'd11;
    localparam logic [ROLE_W-1:0] ROLE_AFTER_ERR = 4'd12;

    // Parse status codes.
    localparam logic [STAT_W-1:0] ST_RUN         = 2'd0;
    localparam logic [STAT_W-1:0] ST_COMPLETE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_TRUNCATED   = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNSUPPORTED = 2'd3;

    // Header layout and field lengths in bytes.
    localparam logic [CNT_W-1:0] HDR_LEN        = 5'd12;
    localparam logic [CNT_W-1:0] HDR_COUNT_POS  = 5'd4;
    localparam logic [CNT_W-1:0] LEN_SHORT      = 5'd2;
    localparam logic [CNT_W-1:0] LEN_TTL        = 5'd4;
    localparam logic [CNT_W-1:0] RDATA_A_LEN    = 5'd4;
    localparam logic [CNT_W-1:0] RDATA_AAAA_LEN = 5'd16;

    // Record types and the unicast-response bit of a question class.
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] TYPE_AAAA    = 16'd28;
    localparam int          UNICAST_BIT  = 15;

    typedef logic [NUM_SEC-1:0][IDX_W-1:0] counts_t;

    // Outcome of the search for the next entry that exists.
    typedef struct packed {
        logic             done;
        logic [SEC_W-1:0] sec;
        logic [IDX_W-1:0] entry;
    } seek_t;

    // One result item.
    typedef struct packed {
        logic [ROLE_W-1:0] byte_role;
        logic [SEC_W-1:0]  section;
        logic [IDX_W-1:0]  entry_index;
        logic [BYTE_W-1:0] byte_value;
        logic              field_done;
        logic [VAL_W-1:0]  field_value;
        logic [STAT_W-1:0] parse_status;
        logic              message_end;
        logic              unicast_wanted;
    } result_t;

endpackage

`default_nettype wire

// File: design/mdns_message_stream_parser.sv
// mDNS message stream parser, one byte per cycle. It takes one datagram byte
// per transaction and returns one result transaction per byte, tagging the
// byte's role, section and entry index, with completed field values. The
// sustained rate is one byte per clock cycle; a byte's result is presented
// on the output once the byte has passed through the input register and
// the result register has captured its result. The rate is set by the parse
// state machine, which computes its whole state update for a byte
// combinationally. Either side may stall freely.
//
// Top level: input register, parse state machine and result register.
// Depends on mdns_pkg, mdns_parse_fsm and mdns_message_stream_parser_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "mdns_message_stream_parser_assert.svh"

module mdns_message_stream_parser
    import mdns_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_data_byte,
    input  wire logic              s_last_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ROLE_W-1:0]      m_byte_role,
    output logic [SEC_W-1:0]       m_section,
    output logic [IDX_W-1:0]       m_entry_index,
    output logic [BYTE_W-1:0]      m_byte_value,
    output logic                   m_field_done,
    output logic [VAL_W-1:0]       m_field_value,
    output logic [STAT_W-1:0]      m_parse_status,
    output logic                   m_message_end,
    output logic                   m_unicast_wanted
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    result_t           res_reg;
    result_t           res;
    logic              out_free;
    logic              step;

    // The result register takes a new transaction when empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    mdns_parse_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .res       (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (step) begin
            res_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_byte_role      = res_reg.byte_role;
    assign m_section        = res_reg.section;
    assign m_entry_index    = res_reg.entry_index;
    assign m_byte_value     = res_reg.byte_value;
    assign m_field_done     = res_reg.field_done;
    assign m_field_value    = res_reg.field_value;
    assign m_parse_status   = res_reg.parse_status;
    assign m_message_end    = res_reg.message_end;
    assign m_unicast_wanted = res_reg.unicast_wanted;

    // Trailing bytes only follow a completed message.
    `MDNS_ASSERT_IMPLIES(a_trailing_complete, aclk, aresetn, out_valid_reg && (res_reg.byte_role == ROLE_TRAILING), res_reg.parse_status == ST_COMPLETE, "trailing byte without completed message")

    // Bytes after an error keep the unsupported-type status.
    `MDNS_ASSERT_IMPLIES(a_error_status, aclk, aresetn, out_valid_reg && (res_reg.byte_role == ROLE_AFTER_ERR), res_reg.parse_status == ST_UNSUPPORTED, "byte after error without error status")

    // Header bytes belong to no section entry.
    `MDNS_ASSERT_IMPLIES(a_header_untagged, aclk, aresetn, out_valid_reg && (res_reg.byte_role <= ROLE_COUNT), (res_reg.section == '0) && (res_reg.entry_index == '0), "header byte tagged with a section entry")

    // A message never ends with the in-progress status.
    `MDNS_ASSERT_IMPLIES(a_end_status, aclk, aresetn, out_valid_reg && res_reg.message_end, res_reg.parse_status != ST_RUN, "message ended while still in progress")

    // A held input byte stays in the input register until it is parsed.
    `MDNS_ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !step, in_valid_reg && $stable(in_data_reg) && $stable(in_last_reg), "input byte lost while stalled")

endmodule

`default_nettype wire

// File: design/mdns_sec_seek.sv
// Finds the next existing entry: stays in the current section while entries
// remain, else skips empty sections. Depends on mdns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdns_sec_seek
    import mdns_pkg::*;
(
    input  wire logic [SEC_W-1:0] cur_sec,
    input  wire logic [IDX_W-1:0] cur_entry,
    input  wire counts_t          counts,
    output seek_t                 seek
);

    logic found;

    always_comb begin
        seek  = '0;
        found = 1'b0;
        // An entry remains in the current section.
        if (cur_entry < counts[cur_sec]) begin
            seek.sec   = cur_sec;
            seek.entry = cur_entry;
            found      = 1'b1;
        end
        // Otherwise the first later section that holds entries.
        for (int s = 1; s < NUM_SEC; s++) begin
            if (!found && (SEC_W'(s) > cur_sec) && (counts[SEC_W'(s)] != '0)) begin
                seek.sec   = SEC_W'(s);
                seek.entry = '0;
                found      = 1'b1;
            end
        end
        seek.done = !found;
    end

endmodule

`default_nettype wire

// File: design/mdns_parse_fsm.sv
// Parse state machine: holds the message walk state and computes the result
// for one byte combinationally. Depends on mdns_pkg and mdns_sec_seek.
`timescale 1ns / 1ps
`default_nettype none

module mdns_parse_fsm
    import mdns_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              last_byte,
    output result_t                res
);

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_NAME   = 4'd1,
        PH_LABEL  = 4'd2,
        PH_TYPE   = 4'd3,
        PH_CLASS  = 4'd4,
        PH_TTL    = 4'd5,
        PH_RDLEN  = 4'd6,
        PH_RDATA  = 4'd7,
        PH_DONE   = 4'd8,
        PH_ERROR  = 4'd9
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        left_reg, left_next;
    logic [VAL_W-1:0]  acc_reg, acc_next;
    counts_t           counts_reg, counts_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [IDX_W-1:0]  ent_reg, ent_next;
    logic [15:0]       rtype_reg, rtype_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              uni_reg, uni_next;

    logic [VAL_W-1:0]  acc_shift;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_off;
    logic [CNT_W-1:0]  rdata_len;
    logic [7:0]        left_dec;
    logic [IDX_W-1:0]  ent_inc;
    logic              hdr;
    logic [SEC_W-1:0]  seek_sec_in;
    logic [IDX_W-1:0]  seek_ent_in;
    seek_t             seek;
    logic              take_seek;

    assign acc_shift = {acc_reg[VAL_W-BYTE_W-1:0], data_byte};
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign cnt_off   = cnt_reg - HDR_COUNT_POS;
    assign left_dec  = left_reg - 8'd1;
    assign ent_inc   = ent_reg + IDX_W'(1);
    assign rdata_len = (rtype_reg == TYPE_AAAA) ? RDATA_AAAA_LEN : RDATA_A_LEN;
    assign hdr       = (phase_reg == PH_HEADER);

    // Section counts, with the count completed by this header byte applied.
    always_comb begin
        counts_next = counts_reg;
        if (hdr && cnt_reg[0] && (cnt_reg >= HDR_COUNT_POS) && (cnt_reg < HDR_LEN)) begin
            counts_next[cnt_off[2:1]] = acc_shift[IDX_W-1:0];
        end
    end

    // The header starts the search at the first question; otherwise the
    // search starts after the entry that just finished.
    assign seek_sec_in = hdr ? '0 : sec_reg;
    assign seek_ent_in = hdr ? '0 : ent_inc;

    mdns_sec_seek u_seek (
        .cur_sec   (seek_sec_in),
        .cur_entry (seek_ent_in),
        .counts    (counts_next),
        .seek      (seek)
    );

    // Next state and result for the byte at hand.
    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        sec_next    = sec_reg;
        ent_next    = ent_reg;
        rtype_next  = rtype_reg;
        status_next = status_reg;
        uni_next    = uni_reg;
        take_seek   = 1'b0;

        res             = '0;
        res.byte_role   = ROLE_ID;
        res.section     = sec_reg;
        res.entry_index = ent_reg;
        res.byte_value  = data_byte;
        res.message_end = last_byte;

        unique case (phase_reg)
            PH_HEADER: begin
                res.section     = '0;
                res.entry_index = '0;
                if (cnt_reg < 5'd2) begin
                    res.byte_role = ROLE_ID;
                end else if (cnt_reg < HDR_COUNT_POS) begin
                    res.byte_role = ROLE_FLAGS;
                end else begin
                    res.byte_role = ROLE_COUNT;
                end
                acc_next = acc_shift;
                if (cnt_reg[0]) begin
                    res.field_done  = 1'b1;
                    res.field_value = {16'd0, acc_shift[15:0]};
                    acc_next        = '0;
                end
                if (cnt_inc >= HDR_LEN) begin
                    cnt_next  = '0;
                    take_seek = 1'b1;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            PH_NAME: begin
                if (data_byte == '0) begin
                    res.byte_role = ROLE_NAME_END;
                    phase_next    = PH_TYPE;
                    cnt_next      = '0;
                    acc_next      = '0;
                end else begin
                    res.byte_role = ROLE_LABEL_LEN;
                    left_next     = data_byte;
                    phase_next    = PH_LABEL;
                end
            end
            PH_LABEL: begin
                res.byte_role = ROLE_LABEL_CHR;
                left_next     = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_NAME;
                end
            end
            PH_TYPE: begin
                res.byte_role = ROLE_TYPE;
                acc_next      = acc_shift;
                cnt_next      = cnt_inc;
                if (cnt_inc >= LEN_SHORT) begin
                    res.field_done  = 1'b1;
                    res.field_value = {16'd0, acc_shift[15:0]};
                    rtype_next      = acc_shift[15:0];
                    acc_next        = '0;
                    cnt_next        = '0;
                    phase_next      = PH_CLASS;
                end
            end
            PH_CLASS: begin
                res.byte_role = ROLE_CLASS;
                acc_next      = acc_shift;
                cnt_next      = cnt_inc;
                if (cnt_inc >= LEN_SHORT) begin
                    res.field_done  = 1'b1;
                    res.field_value = {16'd0, acc_shift[15:0]};
                    acc_next        = '0;
                    cnt_next        = '0;
                    if (sec_reg == '0) begin
                        if (acc_shift[UNICAST_BIT]) begin
                            uni_next = 1'b1;
                        end
                        take_seek = 1'b1;
                    end else begin
                        phase_next = PH_TTL;
                    end
                end
            end
            PH_TTL: begin
                res.byte_role = ROLE_TTL;
                acc_next      = acc_shift;
                cnt_next      = cnt_inc;
                if (cnt_inc >= LEN_TTL) begin
                    res.field_done  = 1'b1;
                    res.field_value = acc_shift;
                    acc_next        = '0;
                    cnt_next        = '0;
                    phase_next      = PH_RDLEN;
                end
            end
            PH_RDLEN: begin
                res.byte_role = ROLE_RDLEN;
                acc_next      = acc_shift;
                cnt_next      = cnt_inc;
                if (cnt_inc >= LEN_SHORT) begin
                    res.field_done  = 1'b1;
                    res.field_value = {16'd0, acc_shift[15:0]};
                    acc_next        = '0;
                    cnt_next        = '0;
                    if ((rtype_reg == TYPE_A) || (rtype_reg == TYPE_AAAA)) begin
                        phase_next = PH_RDATA;
                    end else begin
                        status_next = ST_UNSUPPORTED;
                        phase_next  = PH_ERROR;
                    end
                end
            end
            PH_RDATA: begin
                res.byte_role = ROLE_RDATA;
                acc_next      = acc_shift;
                cnt_next      = cnt_inc;
                if (cnt_inc >= rdata_len) begin
                    res.field_done  = 1'b1;
                    res.field_value = acc_shift;
                    acc_next        = '0;
                    cnt_next        = '0;
                    take_seek       = 1'b1;
                end
            end
            PH_DONE: begin
                res.byte_role   = ROLE_TRAILING;
                res.section     = '0;
                res.entry_index = '0;
            end
            default: begin
                res.byte_role   = ROLE_AFTER_ERR;
                res.section     = '0;
                res.entry_index = '0;
                phase_next      = PH_ERROR;
            end
        endcase

        // Move on to the next existing entry, or finish the message.
        if (take_seek) begin
            if (seek.done) begin
                status_next = ST_COMPLETE;
                phase_next  = PH_DONE;
                sec_next    = '0;
                ent_next    = '0;
            end else begin
                sec_next   = seek.sec;
                ent_next   = seek.entry;
                phase_next = PH_NAME;
            end
        end

        res.parse_status   = (last_byte && (status_next == ST_RUN)) ? ST_TRUNCATED
                                                                    : status_next;
        res.unicast_wanted = uni_next;
    end

    // State update; the final byte of a message returns everything to reset.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            phase_reg  <= PH_HEADER;
            cnt_reg    <= '0;
            left_reg   <= '0;
            acc_reg    <= '0;
            counts_reg <= '0;
            sec_reg    <= '0;
            ent_reg    <= '0;
            rtype_reg  <= '0;
            status_reg <= ST_RUN;
            uni_reg    <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            left_reg   <= left_next;
            acc_reg    <= acc_next;
            counts_reg <= counts_next;
            sec_reg    <= sec_next;
            ent_reg    <= ent_next;
            rtype_reg  <= rtype_next;
            status_reg <= status_next;
            uni_reg    <= uni_next;
        end
    end

endmodule

`default_nettype wire

// File: test/mdns_message_stream_parser_tb.sv
// Self-checking testbench for mdns_message_stream_parser: drives whole mDNS datagrams
// byte by byte and checks every result transaction against a built-in parser model.
// Depends on mdns_pkg and the mdns_message_stream_parser RTL.
`timescale 1ns / 1ps

module mdns_message_stream_parser_tb;
    import mdns_pkg::*;

    // Parser phases of the local model.
    typedef enum logic [3:0] {
        P_HEADER, P_NAME, P_LABEL, P_TYPE, P_CLASS,
        P_TTL, P_RDLEN, P_RDATA, P_DONE, P_ERROR
    } parse_phase_t;

    // How a generated datagram is closed.
    typedef enum logic [1:0] {END_EXACT, END_TRAIL, END_CUT} msg_close_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } dgram_byte_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data_byte = '0;
    logic              s_last_byte = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ROLE_W-1:0] m_byte_role;
    logic [SEC_W-1:0]  m_section;
    logic [IDX_W-1:0]  m_entry_index;
    logic [BYTE_W-1:0] m_byte_value;
    logic              m_field_done;
    logic [VAL_W-1:0]  m_field_value;
    logic [STAT_W-1:0] m_parse_status;
    logic              m_message_end;
    logic              m_unicast_wanted;

    // Stimulus and expectation stores.
    dgram_byte_t       byte_queue[$];
    logic [7:0]        msg_buf[$];
    result_t           expected_tags[$];

    int                mismatches = 0;
    int                msg_count = 0;
    int                checked = 0;
    int                gap_left = 0;
    int                stall_left = 0;
    logic              quiet = 1'b0;
    logic              long_label_pending = 1'b0;

    // Model state.
    parse_phase_t      phase;
    logic [4:0]        field_cnt;
    logic [7:0]        label_left;
    logic [31:0]       accum;
    logic [15:0]       sec_count[NUM_SEC];
    logic [1:0]        cur_sec;
    logic [15:0]       entry_no;
    logic [15:0]       rec_type;
    logic [1:0]        status;
    logic              ucast;

    mdns_message_stream_parser u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_role      (m_byte_role),
        .m_section        (m_section),
        .m_entry_index    (m_entry_index),
        .m_byte_value     (m_byte_value),
        .m_field_done     (m_field_done),
        .m_field_value    (m_field_value),
        .m_parse_status   (m_parse_status),
        .m_message_end    (m_message_end),
        .m_unicast_wanted (m_unicast_wanted)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        phase      = P_HEADER;
        field_cnt  = '0;
        label_left = '0;
        accum      = '0;
        sec_count  = '{default: '0};
        cur_sec    = '0;
        entry_no   = '0;
        rec_type   = '0;
        status     = ST_RUN;
        ucast      = 1'b0;
    endfunction

    // Skip empty sections; when nothing is left the message is complete.
    function automatic void find_entry();
        int s;
        s = int'(cur_sec);
        while (s < NUM_SEC && entry_no >= sec_count[s[1:0]]) begin
            s++;
            entry_no = '0;
        end
        if (s >= NUM_SEC) begin
            status   = ST_COMPLETE;
            phase    = P_DONE;
            cur_sec  = '0;
            entry_no = '0;
        end else begin
            cur_sec = s[1:0];
            phase   = P_NAME;
        end
    endfunction

    // Shift one byte into the field accumulator; true once n bytes are in.
    function automatic bit shift_in(logic [7:0] b, logic [4:0] n);
        accum     = {accum[23:0], b};
        field_cnt = field_cnt + 5'd1;
        return field_cnt >= n;
    endfunction

    function automatic result_t decode_byte(logic [7:0] b, logic last);
        result_t    r;
        logic [4:0] pos;
        logic [4:0] cnt_off;
        r                = '0;
        r.byte_value     = b;
        r.message_end    = last;
        r.section        = cur_sec;
        r.entry_index    = entry_no;
        case (phase)
            P_HEADER: begin
                pos         = field_cnt;
                r.byte_role = (pos < LEN_SHORT) ? ROLE_ID :
                              (pos < HDR_COUNT_POS) ? ROLE_FLAGS : ROLE_COUNT;
                r.section     = '0;
                r.entry_index = '0;
                accum = {accum[23:0], b};
                if (pos[0]) begin
                    r.field_done  = 1'b1;
                    r.field_value = {16'h0, accum[15:0]};
                    if (pos >= HDR_COUNT_POS) begin
                        cnt_off = pos - HDR_COUNT_POS;
                        sec_count[cnt_off[2:1]] = accum[15:0];
                    end
                    accum = '0;
                end
                pos = pos + 5'd1;
                if (pos >= HDR_LEN) begin
                    field_cnt = '0;
                    cur_sec   = '0;
                    entry_no  = '0;
                    find_entry();
                end else begin
                    field_cnt = pos;
                end
            end
            P_NAME: begin
                if (b == 8'd0) begin
                    r.byte_role = ROLE_NAME_END;
                    phase       = P_TYPE;
                    field_cnt   = '0;
                    accum       = '0;
                end else begin
                    r.byte_role = ROLE_LABEL_LEN;
                    label_left  = b;
                    phase       = P_LABEL;
                end
            end
            P_LABEL: begin
                r.byte_role = ROLE_LABEL_CHR;
                label_left  = label_left - 8'd1;
                if (label_left == 8'd0) phase = P_NAME;
            end
            P_TYPE: begin
                r.byte_role = ROLE_TYPE;
                if (shift_in(b, LEN_SHORT)) begin
                    r.field_done  = 1'b1;
                    r.field_value = {16'h0, accum[15:0]};
                    rec_type      = accum[15:0];
                    accum         = '0;
                    field_cnt     = '0;
                    phase         = P_CLASS;
                end
            end
            P_CLASS: begin
                r.byte_role = ROLE_CLASS;
                if (shift_in(b, LEN_SHORT)) begin
                    r.field_done  = 1'b1;
                    r.field_value = {16'h0, accum[15:0]};
                    // Questions end at the class; records carry on with the ttl.
                    if (cur_sec == 2'd0) begin
                        if (accum[UNICAST_BIT]) ucast = 1'b1;
                        entry_no = entry_no + 16'd1;
                        find_entry();
                    end else begin
                        phase = P_TTL;
                    end
                    accum     = '0;
                    field_cnt = '0;
                end
            end
            P_TTL: begin
                r.byte_role = ROLE_TTL;
                if (shift_in(b, LEN_TTL)) begin
                    r.field_done  = 1'b1;
                    r.field_value = accum;
                    accum         = '0;
                    field_cnt     = '0;
                    phase         = P_RDLEN;
                end
            end
            P_RDLEN: begin
                r.byte_role = ROLE_RDLEN;
                if (shift_in(b, LEN_SHORT)) begin
                    r.field_done  = 1'b1;
                    r.field_value = {16'h0, accum[15:0]};
                    accum         = '0;
                    field_cnt     = '0;
                    if (rec_type == TYPE_A || rec_type == TYPE_AAAA) begin
                        phase = P_RDATA;
                    end else begin
                        status = ST_UNSUPPORTED;
                        phase  = P_ERROR;
                    end
                end
            end
            P_RDATA: begin
                r.byte_role = ROLE_RDATA;
                if (shift_in(b, (rec_type == TYPE_AAAA) ? RDATA_AAAA_LEN : RDATA_A_LEN)) begin
                    r.field_done  = 1'b1;
                    r.field_value = accum;
                    accum         = '0;
                    field_cnt     = '0;
                    entry_no      = entry_no + 16'd1;
                    find_entry();
                end
            end
            P_DONE: begin
                r.byte_role   = ROLE_TRAILING;
                r.section     = '0;
                r.entry_index = '0;
            end
            default: begin
                r.byte_role   = ROLE_AFTER_ERR;
                r.section     = '0;
                r.entry_index = '0;
                phase         = P_ERROR;
            end
        endcase
        r.parse_status   = (last && status == ST_RUN) ? ST_TRUNCATED : status;
        r.unicast_wanted = ucast;
        if (last) clear_parser();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Datagram builders
    // ------------------------------------------------------------------

    // Append one byte to the datagram under construction.
    task automatic buf_byte(input logic [7:0] b);
        msg_buf.insert(msg_buf.size(), b);
    endtask

    task automatic put16(input logic [15:0] v);
        buf_byte(v[15:8]);
        buf_byte(v[7:0]);
    endtask

    function automatic logic [7:0] pick_label_len();
        if (long_label_pending) begin
            long_label_pending = 1'b0;
            return 8'd255;
        end
        if ($urandom_range(0, 24) == 0) return 8'($urandom_range(64, 255));
        return 8'($urandom_range(1, 10));
    endfunction

    task automatic put_name(input int labels);
        logic [7:0] len;
        for (int i = 0; i < labels; i++) begin
            len = pick_label_len();
            buf_byte(len);
            repeat (len) buf_byte(8'($urandom));
        end
        buf_byte(8'd0);
    endtask

    task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                              input logic [15:0] qd, input logic [15:0] an,
                              input logic [15:0] ns, input logic [15:0] ar);
        put16(id);
        put16(flags);
        put16(qd);
        put16(an);
        put16(ns);
        put16(ar);
    endtask

    task automatic put_question(input logic [15:0] qclass);
        put_name($urandom_range(0, 3));
        put16(16'($urandom));
        put16(qclass);
    endtask

    // A record; an unsupported type is followed by up to three stray bytes.
    task automatic put_record(input logic [15:0] rtype);
        put_name($urandom_range(0, 3));
        put16(rtype);
        put16(16'($urandom));
        put16(16'($urandom));
        put16(16'($urandom));
        put16(16'($urandom));
        if (rtype == TYPE_A)
            repeat (RDATA_A_LEN) buf_byte(8'($urandom));
        else if (rtype == TYPE_AAAA)
            repeat (RDATA_AAAA_LEN) buf_byte(8'($urandom));
        else
            repeat ($urandom_range(0, 3)) buf_byte(8'($urandom));
    endtask

    function automatic logic [15:0] pick_rtype(bit bad);
        logic [15:0] t;
        if (!bad) return $urandom_range(0, 1) ? TYPE_A : TYPE_AAAA;
        do t = 16'($urandom); while (t == TYPE_A || t == TYPE_AAAA);
        return t;
    endfunction

    // Close the datagram in msg_buf and queue its bytes for the driver.
    task automatic send_message(input msg_close_t how);
        int          keep;
        dgram_byte_t item;
        if (how == END_CUT && msg_buf.size() > 1) begin
            keep = $urandom_range(1, msg_buf.size() - 1);
            while (msg_buf.size() > keep) void'(msg_buf.pop_back());
        end else if (how == END_TRAIL) begin
            repeat ($urandom_range(1, 4)) buf_byte(8'($urandom));
        end
        foreach (msg_buf[i]) begin
            item.data = msg_buf[i];
            item.last = (i == msg_buf.size() - 1);
            byte_queue.insert(byte_queue.size(), item);
        end
        msg_buf.delete();
        msg_count++;
    endtask

    task automatic build_random(input bit bad);
        int qd, an, ns, ar, total, bad_at;
        logic [15:0] rtype;
        qd = $urandom_range(0, 3);
        an = $urandom_range(0, 2);
        ns = $urandom_range(0, 2);
        ar = $urandom_range(0, 2);
        if (bad && an + ns + ar == 0) an = 1;
        total  = an + ns + ar;
        bad_at = (total > 0) ? $urandom_range(0, total - 1) : 0;
        put_header(16'($urandom), 16'($urandom), 16'(qd), 16'(an), 16'(ns), 16'(ar));
        repeat (qd) put_question({1'($urandom_range(0, 1)), 15'($urandom)});
        for (int i = 0; i < total; i++) begin
            rtype = pick_rtype(bad && i == bad_at);
            put_record(rtype);
            if (rtype != TYPE_A && rtype != TYPE_AAAA) break;
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        dgram_byte_t item;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_data_byte <= '0;
            s_last_byte <= 1'b0;
            quiet       <= 1'b0;
        end else begin
            quiet <= (byte_queue.size() < 40);
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 4);
                    s_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    item = byte_queue.pop_front();
                    s_valid     <= 1'b1;
                    s_data_byte <= item.data;
                    s_last_byte <= item.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and checker
    // ------------------------------------------------------------------

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (mismatches < 40)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, fname, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_tags.size() == 0) begin
            $display("%0t ns: result transaction with no byte outstanding, role 0x%0h",
                     $time, m_byte_role);
            mismatches++;
        end else begin
            want = expected_tags.pop_front();
            check_field("byte_role", 32'(want.byte_role), 32'(m_byte_role));
            check_field("section", 32'(want.section), 32'(m_section));
            check_field("entry_index", 32'(want.entry_index), 32'(m_entry_index));
            check_field("byte_value", 32'(want.byte_value), 32'(m_byte_value));
            check_field("field_done", 32'(want.field_done), 32'(m_field_done));
            check_field("field_value", want.field_value, m_field_value);
            check_field("parse_status", 32'(want.parse_status), 32'(m_parse_status));
            check_field("message_end", 32'(want.message_end), 32'(m_message_end));
            check_field("unicast_wanted", 32'(want.unicast_wanted),
                        32'(m_unicast_wanted));
            checked++;
        end
    endtask

    // The result check runs before the new byte is modeled, so the oldest
    // expectation is always the one for the result being accepted.
    always @(posedge aclk) begin
        result_t tag;
        if (!aresetn) begin
            m_ready <= 1'b0;
            clear_parser();
        end else begin
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready) begin
                tag = decode_byte(s_data_byte, s_last_byte);
                expected_tags.insert(expected_tags.size(), tag);
            end
            if (stall_left != 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial begin
        int directed_bytes;
        int pick;
        msg_close_t how;
        clear_parser();

        // Header only, extreme id and flags, nothing to parse after it.
        put_header(16'hFFFF, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0);
        send_message(END_EXACT);
        // Header only with trailing bytes after completion.
        put_header(16'h0000, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        send_message(END_TRAIL);
        // One entry in every section: unicast question, A and AAAA records.
        put_header(16'($urandom), 16'($urandom), 16'd1, 16'd1, 16'd1, 16'd1);
        put_question(16'h8001);
        put_record(TYPE_A);
        put_record(TYPE_A);
        put_record(TYPE_AAAA);
        send_message(END_EXACT);
        // Unsupported record types, the error state and bytes after it.
        put_header(16'($urandom), 16'($urandom), 16'd0, 16'd1, 16'd0, 16'd0);
        put_record(16'h0000);
        send_message(END_EXACT);
        put_header(16'($urandom), 16'($urandom), 16'd0, 16'd0, 16'd0, 16'd1);
        put_record(16'hFFFF);
        send_message(END_TRAIL);
        // Maximum counts, cut short after one question.
        put_header(16'($urandom), 16'($urandom), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        put_question(16'h0001);
        send_message(END_EXACT);
        // A datagram of a single byte.
        buf_byte(8'hA5);
        send_message(END_EXACT);
        // Two questions, only the second asks for a unicast reply.
        put_header(16'($urandom), 16'($urandom), 16'd2, 16'd0, 16'd0, 16'd0);
        put_question(16'h7FFF);
        put_question(16'h8000);
        send_message(END_EXACT);
        // A message with an AAAA record, truncated at a random byte.
        put_header(16'($urandom), 16'($urandom), 16'd0, 16'd1, 16'd0, 16'd0);
        put_record(TYPE_AAAA);
        send_message(END_CUT);

        // Random datagrams: mostly well formed, some broken, some noise.
        long_label_pending = 1'b1;
        while (byte_queue.size() < 400) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 20)) buf_byte(8'($urandom));
                send_message(END_EXACT);
            end else begin
                build_random(pick == 1);
                pick = $urandom_range(0, 19);
                how  = (pick < 14) ? END_EXACT : (pick < 17) ? END_TRAIL : END_CUT;
                send_message(how);
            end
        end
        directed_bytes = byte_queue.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_queue.size() != 0 || s_valid) @(posedge aclk);
        while (expected_tags.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d datagrams (%0d bytes) and checked %0d result transactions,",
                 msg_count, directed_bytes, checked);
        $display("covering complete, trailing, truncated, unsupported-type and noise traffic.");
        if (mismatches == 0) begin
            $display("[mdns_message_stream_parser] OK");
        end else begin
            $display("[mdns_message_stream_parser] ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("Timeout with %0d bytes unsent and %0d results outstanding.",
                 byte_queue.size(), expected_tags.size());
        $display("[mdns_message_stream_parser] ERROR");
        $finish;
    end

endmodule
